### hdl/modified_utf8_to_utf8_core_assert.svh
// Assertion macros for the modified UTF-8 to UTF-8 converter.
`ifndef MODIFIED_UTF8_TO_UTF8_CORE_ASSERT_SVH
`define MODIFIED_UTF8_TO_UTF8_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, clocked on clk, quiet during reset
`define MU8_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mu8 assertion failed");
// next-cycle implication
`define MU8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mu8 assertion failed");
`else
`define MU8_ASSERT_NOW(label, ante, cons)
`define MU8_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/mu8_pkg.sv
// Shared types and constants of the modified UTF-8 to UTF-8 converter.
`default_nettype none
package mu8_pkg;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_LEAD  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  localparam logic [7:0] LEAD_SURR = 8'hED;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_string_end;
    logic [1:0] error_code;
  } out_item_t;

  // one input transaction's worth of output: 1 to 4 bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic [1:0]      err;      // error code of the last byte
    logic            str_end;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic idle;
  } front_stat_t;

endpackage
`default_nettype wire

### hdl/modified_utf8_to_utf8_core.sv
// Path: an accepted byte's results go through the command queue, then the output queue.
// Throughput: one input byte per cycle unless the command queue is full, one result
//   per cycle while the output queue has room; a surrogate pair's four bytes or a
//   three-byte flush is absorbed by the 4-entry command queue before full rises.
// Reset: synchronous, active low; empties both queues and returns to the idle phase.
`default_nettype none
`include "modified_utf8_to_utf8_core_assert.svh"
module modified_utf8_to_utf8_core (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               push,
  output logic               full,
  input  mu8_pkg::in_item_t  in_data,
  // result channel
  output logic               empty,
  input  logic               pop,
  output mu8_pkg::out_item_t out_data
);
  import mu8_pkg::*;

  // Front end: phase tracking and held bytes, one command per transaction
  // that yields output. Back end: drains commands byte by byte.
  logic        accept;
  logic        cmd_push, cmd_pop, out_push;
  cmd_t        cmd_in, cmd_head;
  q_stat_t     cmd_stat, out_stat;
  front_stat_t fr_stat;
  out_item_t   out_item;

  assign full   = cmd_stat.full;
  assign accept = push && !cmd_stat.full;
  assign empty  = out_stat.empty;

  mu8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .stat     (fr_stat)
  );

  mu8_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .stat  (cmd_stat)
  );

  mu8_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd_head),
    .cmd_stat (cmd_stat),
    .cmd_pop  (cmd_pop),
    .out_stat (out_stat),
    .out_push (out_push),
    .out_item (out_item)
  );

  // result register stage; lets the serializer run while the sink stalls
  mu8_out_q u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_item),
    .pop   (pop),
    .rdata (out_data),
    .stat  (out_stat)
  );

  // string end always closes a transaction's run
  `MU8_ASSERT_NOW(a_end_is_last, !empty && out_data.out_string_end, out_data.run_last)
  // error results carry a zero byte and end their run
  `MU8_ASSERT_NOW(a_err_shape, !empty && out_data.error_code != ERR_NONE,
                  out_data.out_byte == 8'h00 && out_data.run_last)
  // a string's last byte leaves nothing held
  `MU8_ASSERT_NEXT(a_end_idle, accept && in_data.in_string_end, fr_stat.idle)

endmodule
`default_nettype wire

### hdl/mu8_front.sv
// Front end: tracks sequence phase, holds partial bytes, builds output commands.
`default_nettype none
module mu8_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  mu8_pkg::in_item_t    in_item,
  output logic                 cmd_push,
  output mu8_pkg::cmd_t        cmd,
  output mu8_pkg::front_stat_t stat
);
  import mu8_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TWO    = 3'd1,
    PH_THREE1 = 3'd2,
    PH_THREE2 = 3'd3,
    PH_HELD   = 3'd4,
    PH_PAIR1  = 3'd5,
    PH_PAIR2  = 3'd6
  } phase_t;

  phase_t     phase_r, phase_nxt;
  // held bytes: first half 0..2, second-half continuation at 3
  logic [7:0] held_r   [4];
  logic [7:0] held_nxt [4];

  logic [7:0]  b;
  logic        str_end;
  logic        lead;
  logic [2:0]  n;
  logic [20:0] cp;
  cmd_t        c;

  assign b       = in_item.in_byte;
  assign str_end = in_item.in_string_end;
  assign cp      = {held_r[1][3:0], held_r[2][5:0], held_r[3][3:0], b[5:0]} + 21'h10000;

  always_comb begin
    c         = '0;
    n         = 3'd0;
    lead      = 1'b0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_TWO: begin
        phase_nxt = PH_IDLE;
        if ({held_r[0][4:0], b[5:0]} == 11'd0) begin
          n = 3'd1;
        end else begin
          c.bytes[0] = held_r[0];
          c.bytes[1] = b;
          n          = 3'd2;
        end
      end
      PH_THREE1: begin
        held_nxt[1] = b;
        if (str_end) begin
          phase_nxt = PH_IDLE;
          c.err     = ERR_TRUNC;
          n         = 3'd1;
        end else begin
          phase_nxt = PH_THREE2;
        end
      end
      PH_THREE2: begin
        held_nxt[2] = b;
        if (str_end) begin
          phase_nxt  = PH_IDLE;
          c.bytes[0] = held_r[0];
          c.bytes[1] = held_r[1];
          c.bytes[2] = b;
          n          = 3'd3;
        end else begin
          phase_nxt = PH_HELD;
        end
      end
      PH_HELD: begin
        if (!str_end && b == LEAD_SURR && held_r[0] == LEAD_SURR) begin
          phase_nxt = PH_PAIR1;
        end else begin
          c.bytes[0] = held_r[0];
          c.bytes[1] = held_r[1];
          c.bytes[2] = held_r[2];
          n          = 3'd3;
          lead       = 1'b1;
        end
      end
      PH_PAIR1: begin
        held_nxt[3] = b;
        if (str_end) begin
          phase_nxt  = PH_IDLE;
          c.bytes[0] = held_r[0];
          c.bytes[1] = held_r[1];
          c.bytes[2] = held_r[2];
          c.err      = ERR_TRUNC;
          n          = 3'd4;
        end else begin
          phase_nxt = PH_PAIR2;
        end
      end
      PH_PAIR2: begin
        phase_nxt  = PH_IDLE;
        c.bytes[0] = {5'b11110, cp[20:18]};
        c.bytes[1] = {2'b10, cp[17:12]};
        c.bytes[2] = {2'b10, cp[11:6]};
        c.bytes[3] = {2'b10, cp[5:0]};
        n          = 3'd4;
      end
      default: begin
        lead = 1'b1;
      end
    endcase

    // byte in lead position; appended after any flushed bytes
    if (lead) begin
      phase_nxt = PH_IDLE;
      priority if (b <= 8'h7F) begin
        c.bytes[n[1:0]] = b;
        n               = n + 3'd1;
      end else if ((b & 8'hE0) == 8'hC0) begin
        held_nxt[0] = b;
        if (str_end) begin
          c.err = ERR_TRUNC;
          n     = n + 3'd1;
        end else begin
          phase_nxt = PH_TWO;
        end
      end else if ((b & 8'hF0) == 8'hE0) begin
        held_nxt[0] = b;
        if (str_end) begin
          c.err = ERR_TRUNC;
          n     = n + 3'd1;
        end else begin
          phase_nxt = PH_THREE1;
        end
      end else begin
        c.err = ERR_LEAD;
        n     = n + 3'd1;
      end
    end

    c.cnt     = n;
    c.str_end = str_end;
  end

  assign cmd       = c;
  assign cmd_push  = accept && (n != 3'd0);
  assign stat.idle = (phase_r == PH_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/mu8_cmd_q.sv
// Command queue between the front end and the serializer.
`default_nettype none
module mu8_cmd_q (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mu8_pkg::cmd_t    wdata,
  input  logic             pop,
  output mu8_pkg::cmd_t    rdata,
  output mu8_pkg::q_stat_t stat
);
  import mu8_pkg::*;

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, rp_r;
  logic [CMDQ_CW-1:0] cnt_r;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### hdl/mu8_back.sv
// Serializer: walks the head command, one output byte per cycle when not stalled.
`default_nettype none
module mu8_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mu8_pkg::cmd_t      cmd,
  input  mu8_pkg::q_stat_t   cmd_stat,
  output logic               cmd_pop,
  input  mu8_pkg::q_stat_t   out_stat,
  output logic               out_push,
  output mu8_pkg::out_item_t out_item
);
  import mu8_pkg::*;

  logic [1:0] slot_r;
  logic       last;

  assign last     = ({1'b0, slot_r} == (cmd.cnt - 3'd1));
  assign out_push = !cmd_stat.empty && !out_stat.full;
  assign cmd_pop  = out_push && last;

  assign out_item.out_byte       = cmd.bytes[slot_r];
  assign out_item.run_last       = last;
  assign out_item.out_string_end = last && cmd.str_end;
  assign out_item.error_code     = last ? cmd.err : ERR_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (out_push) begin
      slot_r <= last ? 2'd0 : slot_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

### hdl/mu8_out_q.sv
// Output queue holding finished result bytes.
`default_nettype none
module mu8_out_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mu8_pkg::out_item_t wdata,
  input  logic               pop,
  output mu8_pkg::out_item_t rdata,
  output mu8_pkg::q_stat_t   stat
);
  import mu8_pkg::*;

  out_item_t          mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wp_r, rp_r;
  logic [OUTQ_CW-1:0] cnt_r;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == OUTQ_CW'(OUTQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### tb/sv/modified_utf8_to_utf8_core_tb.sv
// Self-checking testbench for the modified UTF-8 to standard UTF-8 converter core.
module modified_utf8_to_utf8_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mu8_pkg::*;

  // Conversion phases of the local predictor (the package defines none).
  typedef enum logic [2:0] {
    CV_IDLE, CV_TWO, CV_THREE1, CV_THREE2, CV_HELD, CV_PAIR1, CV_PAIR2
  } conv_phase_t;

  // Kinds of character the random string builder emits.
  typedef enum int {
    CH_ASCII, CH_TWO, CH_NUL, CH_THREE, CH_SURR3, CH_PAIR, CH_NOISE
  } char_kind_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_data = '0;
  out_item_t out_data;

  modified_utf8_to_utf8_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Converter predictor: its own phase and held bytes, mirrored per accepted
  // input transaction. Expected output bytes queue up in utf8_exp_q.
  // ---------------------------------------------------------------------------
  conv_phase_t cv_phase = CV_IDLE;
  logic [7:0]  cv_held [5];
  out_item_t   utf8_exp_q [$];

  function automatic out_item_t mk_result(logic [7:0] b, logic [1:0] err);
    out_item_t r;
    r.out_byte       = b;
    r.run_last       = 1'b0;
    r.out_string_end = 1'b0;
    r.error_code     = err;
    return r;
  endfunction

  // Flush the three bytes of a held three-byte sequence.
  task automatic flush_held(ref out_item_t res [$]);
    for (int k = 0; k < 3; k++) res.insert(res.size(), mk_result(cv_held[k], ERR_NONE));
  endtask

  // A byte seen where a lead byte is expected.
  task automatic take_lead(logic [7:0] b, logic str_end, ref out_item_t res [$]);
    cv_phase = CV_IDLE;
    if (b <= 8'h7F) begin
      res.insert(res.size(), mk_result(b, ERR_NONE));
    end else if ((b & 8'hE0) == 8'hC0) begin
      cv_held[0] = b;
      if (str_end) res.insert(res.size(), mk_result(8'h00, ERR_TRUNC));
      else cv_phase = CV_TWO;
    end else if ((b & 8'hF0) == 8'hE0) begin
      cv_held[0] = b;
      if (str_end) res.insert(res.size(), mk_result(8'h00, ERR_TRUNC));
      else cv_phase = CV_THREE1;
    end else begin
      // continuation byte or 1111xxxx in lead position
      res.insert(res.size(), mk_result(8'h00, ERR_LEAD));
    end
  endtask

  task automatic convert_byte(in_item_t it);
    out_item_t   res [$];
    out_item_t   tail;
    logic [7:0]  b;
    logic        str_end;
    logic [31:0] cp;
    b       = it.in_byte;
    str_end = it.in_string_end;
    case (cv_phase)
      CV_TWO: begin
        cv_phase = CV_IDLE;
        // C0 80 and any other overlong zero collapse to one 00 byte
        if (cv_held[0][4:0] == 5'd0 && b[5:0] == 6'd0) begin
          res.insert(res.size(), mk_result(8'h00, ERR_NONE));
        end else begin
          res.insert(res.size(), mk_result(cv_held[0], ERR_NONE));
          res.insert(res.size(), mk_result(b, ERR_NONE));
        end
      end
      CV_THREE1: begin
        cv_held[1] = b;
        if (str_end) begin
          cv_phase = CV_IDLE;
          res.insert(res.size(), mk_result(8'h00, ERR_TRUNC));
        end else begin
          cv_phase = CV_THREE2;
        end
      end
      CV_THREE2: begin
        cv_held[2] = b;
        if (str_end) begin
          cv_phase = CV_IDLE;
          flush_held(res);
        end else begin
          cv_phase = CV_HELD;
        end
      end
      CV_HELD: begin
        // only an ED following an ED-led sequence opens a surrogate pair
        if (!str_end && b == LEAD_SURR && cv_held[0] == LEAD_SURR) begin
          cv_held[3] = b;
          cv_phase   = CV_PAIR1;
        end else begin
          flush_held(res);
          take_lead(b, str_end, res);
        end
      end
      CV_PAIR1: begin
        cv_held[4] = b;
        if (str_end) begin
          cv_phase = CV_IDLE;
          flush_held(res);
          res.insert(res.size(), mk_result(8'h00, ERR_TRUNC));
        end else begin
          cv_phase = CV_PAIR2;
        end
      end
      CV_PAIR2: begin
        cp = 32'h10000
           + ({28'd0, cv_held[1][3:0]} << 16)
           + ({26'd0, cv_held[2][5:0]} << 10)
           + ({28'd0, cv_held[4][3:0]} << 6)
           + {26'd0, b[5:0]};
        cv_phase = CV_IDLE;
        res.insert(res.size(), mk_result({5'b11110, cp[20:18]}, ERR_NONE));
        res.insert(res.size(), mk_result({2'b10, cp[17:12]}, ERR_NONE));
        res.insert(res.size(), mk_result({2'b10, cp[11:6]}, ERR_NONE));
        res.insert(res.size(), mk_result({2'b10, cp[5:0]}, ERR_NONE));
      end
      default: take_lead(b, str_end, res);
    endcase
    if (res.size() > 0) begin
      tail          = res.pop_back();
      tail.run_last = 1'b1;
      if (str_end) tail.out_string_end = 1'b1;
      res.insert(res.size(), tail);
    end
    foreach (res[k]) utf8_exp_q.insert(utf8_exp_q.size(), res[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: strings of bytes, end flag on the last byte of each string.
  // ---------------------------------------------------------------------------
  in_item_t src_q [$];
  int       drain_idx = -1;  // sender waits for a full drain before this byte

  task automatic add_byte(logic [7:0] b, logic str_end);
    in_item_t it;
    it.in_byte       = b;
    it.in_string_end = str_end;
    src_q.insert(src_q.size(), it);
  endtask

  // Continuation bytes are not checked by the block, so now and then use any byte.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic build_char(char_kind_t kind, ref logic [7:0] seq [$]);
    case (kind)
      CH_ASCII: seq.insert(seq.size(), 8'($urandom_range(0, 127)));
      CH_TWO: begin
        seq.insert(seq.size(), 8'hC0 | 8'($urandom_range(0, 31)));
        seq.insert(seq.size(), cont_byte());
      end
      CH_NUL: begin
        seq.insert(seq.size(), 8'hC0);
        seq.insert(seq.size(), 8'h80);
      end
      CH_THREE: begin
        seq.insert(seq.size(), 8'hE0 | 8'($urandom_range(0, 15)));
        seq.insert(seq.size(), cont_byte());
        seq.insert(seq.size(), cont_byte());
      end
      CH_SURR3: begin
        seq.insert(seq.size(), LEAD_SURR);
        seq.insert(seq.size(), cont_byte());
        seq.insert(seq.size(), cont_byte());
      end
      CH_PAIR: begin
        seq.insert(seq.size(), LEAD_SURR);
        seq.insert(seq.size(), 8'hA0 | 8'($urandom_range(0, 15)));
        seq.insert(seq.size(), cont_byte());
        seq.insert(seq.size(), LEAD_SURR);
        seq.insert(seq.size(), 8'hB0 | 8'($urandom_range(0, 15)));
        seq.insert(seq.size(), cont_byte());
      end
      default: seq.insert(seq.size(), 8'($urandom_range(0, 255)));
    endcase
  endtask

  // Mostly well-formed strings with random content; some noise and cut-off endings.
  task automatic add_random_string();
    logic [7:0] str [$];
    logic [7:0] part [$];
    int         nch;
    int         pick;
    int         keep;
    nch = $urandom_range(1, 6);
    for (int i = 0; i < nch; i++) begin
      pick = $urandom_range(0, 99);
      part.delete();
      if (pick < 20)      build_char(CH_ASCII, part);
      else if (pick < 32) build_char(CH_TWO, part);
      else if (pick < 38) build_char(CH_NUL, part);
      else if (pick < 52) build_char(CH_THREE, part);
      else if (pick < 60) build_char(CH_SURR3, part);
      else if (pick < 82) build_char(CH_PAIR, part);
      else if (pick < 90) build_char(CH_NOISE, part);
      else begin
        // string ends partway through a multi-byte sequence
        build_char(char_kind_t'(pick < 93 ? CH_TWO : (pick < 96 ? CH_THREE : CH_PAIR)),
                   part);
        keep = $urandom_range(1, part.size() - 1);
        while (part.size() > keep) void'(part.pop_back());
        foreach (part[k]) str.insert(str.size(), part[k]);
        break;
      end
      foreach (part[k]) str.insert(str.size(), part[k]);
    end
    foreach (str[k]) add_byte(str[k], k == str.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Handshake sampling, result checking and prediction, all at the rising edge.
  // ---------------------------------------------------------------------------
  bit        in_fire;
  bit        out_fire;
  int        acc_cnt;       // accepted input transactions
  int        res_cnt;       // checked result transactions
  int        err_res_cnt;   // checked results carrying an error code
  int        mismatch_cnt;
  out_item_t want;

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    in_fire  = rst_n && push && !full;
    out_fire = rst_n && pop && !empty;
    if (out_fire) begin
      if (utf8_exp_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with nothing expected: expected none, actual %p",
                 $time, out_data);
      end else begin
        want = utf8_exp_q.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("run_last", want.run_last, out_data.run_last);
        check_field("out_string_end", want.out_string_end, out_data.out_string_end);
        check_field("error_code", want.error_code, out_data.error_code);
        res_cnt++;
        if (want.error_code != ERR_NONE) err_res_cnt++;
      end
    end
    if (in_fire) begin
      convert_byte(in_data);
      acc_cnt++;
    end
  end

  // Between these accept counts neither side idles; the long receiver stall
  // starts inside this window so the sender keeps pushing and hits full.
  function automatic int draw_gap();
    if (acc_cnt >= 40 && acc_cnt < 90) return 0;
    return $urandom_range(0, 4);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one byte per transaction from src_q, changes at the falling edge.
  // push stays up until the transaction is taken.
  // ---------------------------------------------------------------------------
  int in_gap;
  int sent_cnt;

  always @(negedge clk) begin
    if (rst_n && !(push && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (src_q.size() == 0 ||
                   (sent_cnt == drain_idx && utf8_exp_q.size() != 0)) begin
        // out of bytes, or pausing until every expected result is out
        push <= 1'b0;
      end else begin
        in_data <= src_q.pop_front();
        push    <= 1'b1;
        sent_cnt++;
        in_gap = draw_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random gap per result, plus one long stall counted here.
  // ---------------------------------------------------------------------------
  int out_gap;
  int stall_left;
  bit stall_done;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) out_gap = draw_gap();
      if (!stall_done && acc_cnt >= 45) begin
        stall_done = 1'b1;
        stall_left = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the byte stream, release reset, wait for the drain.
  // ---------------------------------------------------------------------------
  initial begin
    // ASCII extremes
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b1);
    // two-byte encoded zero
    add_byte(8'hC0, 1'b0);
    add_byte(8'h80, 1'b1);
    // two-byte lead cut off by string end
    add_byte(8'hC0, 1'b1);
    // invalid leads: bare continuation byte and 1111xxxx
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b1);
    // surrogate pair, combined into F0 9F 92 A9
    add_byte(8'hED, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte(8'hBD, 1'b0);
    add_byte(8'hED, 1'b0);
    add_byte(8'hB2, 1'b0);
    add_byte(8'hA9, 1'b1);
    // held three-byte flushed by an invalid lead at string end
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hAC, 1'b0);
    add_byte(8'hF5, 1'b1);
    // string ends right on a held three-byte sequence
    add_byte(8'hE4, 1'b0);
    add_byte(8'hB8, 1'b0);
    add_byte(8'hAD, 1'b1);
    // pair cut off in its second half
    add_byte(8'hED, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hED, 1'b0);
    add_byte(8'hB0, 1'b1);
    // three-byte cut off after two bytes
    add_byte(8'hE0, 1'b0);
    add_byte(8'h80, 1'b1);

    drain_idx = src_q.size() + 70;
    while (src_q.size() < 130) add_random_string();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (src_q.size() != 0 || push) @(posedge clk);
    while (utf8_exp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Converted %0d input bytes into %0d output bytes (%0d error results),",
             acc_cnt, res_cnt, err_res_cnt);
    $display("with random gaps on both sides, one long output stall and one full drain.");
    if (mismatch_cnt == 0 && utf8_exp_q.size() == 0) begin
      $display("PASS modified_utf8_to_utf8_core");
    end else begin
      $display("FAIL modified_utf8_to_utf8_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500_000;
    $display("FAIL modified_utf8_to_utf8_core");
    $finish;
  end

endmodule
